// ===== src/linear_probe_map_table_core_defines.svh =====
// assertion macros used by the checker file
`ifndef LINEAR_PROBE_MAP_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_MAP_TABLE_CORE_DEFINES_SVH

// property that must hold at every edge outside reset
`define LPMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LPMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lpmt_pkg.sv =====
// shared constants and types of the linear probing map table
package lpmt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int NUM_W       = SLOT_W + 1;
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int TSIZE_W     = 11;
  localparam int CNT_W       = $clog2(KEY_W);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1024;

  // register index taken from paddr above the byte offset
  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_CREATE = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EXISTS    = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic             ever_used;
    logic             live;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

// ===== src/linear_probe_map_table_core.sv =====
// top level of the linear probing map table
//
// Input words (req_type, key, new_value, exclusive) are taken when in_valid is
// high and in_stall is low; one result word (status, found_value, slot,
// was_present) leaves per request when out_valid is high and out_stall low.
// The table holds up to 1024 key/value slots with live and ever-used marks;
// table_size, written over the APB port at address 0, sets the probe modulus.
//
// One request is worked at a time. The start slot key mod size comes from a
// bit-serial remainder unit, then the probe reads one slot per cycle from the
// slot memory, and the result is loaded into the output register. in_stall
// is high while a request is in work.
//
// After reset a clearing pass writes every slot to empty, with in_stall high;
// configuration writes are taken throughout. A waiting result is held stable
// while out_stall is high, and the next request is accepted meanwhile; it then
// waits in its last step until the output register frees.
module linear_probe_map_table_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic [lpmt_pkg::KEY_W-1:0]          key,
  input  logic [lpmt_pkg::VAL_W-1:0]          new_value,
  input  logic                                exclusive,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [lpmt_pkg::VAL_W-1:0]          found_value,
  output logic [lpmt_pkg::SLOT_W-1:0]         slot,
  output logic                                was_present,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpmt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lpmt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lpmt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  lpmt_pkg::state_t state, state_next;

  logic [lpmt_pkg::TSIZE_W-1:0] table_size;
  logic                         cfg_wr;
  logic                         cfg_sel;

  logic [lpmt_pkg::NUM_W-1:0]  eff_n;
  logic [lpmt_pkg::NUM_W-1:0]  n_q;
  logic [lpmt_pkg::SLOT_W-1:0] nm1;
  logic [1:0]                  req_q;
  logic [lpmt_pkg::KEY_W-1:0]  key_q;
  logic [lpmt_pkg::VAL_W-1:0]  nval_q;
  logic                        excl_q;

  logic [lpmt_pkg::SLOT_W-1:0] at;
  logic [lpmt_pkg::SLOT_W-1:0] cnt;
  logic [lpmt_pkg::SLOT_W-1:0] clr_addr;
  logic [lpmt_pkg::NUM_W-1:0]  at_inc;
  logic [lpmt_pkg::SLOT_W-1:0] at_wrap;

  logic [1:0]                  res_status, res_status_next;
  logic [lpmt_pkg::VAL_W-1:0]  res_value, res_value_next;
  logic                        res_live;

  logic                        accept;
  logic                        rem_start;
  logic                        rem_done;
  logic [lpmt_pkg::SLOT_W-1:0] rem;

  logic                        we;
  logic [lpmt_pkg::SLOT_W-1:0] waddr;
  lpmt_pkg::slot_t             wdata;
  logic [lpmt_pkg::SLOT_W-1:0] raddr;
  lpmt_pkg::slot_t             rd;

  logic hit_never, hit_key, hit_tomb, stop, exhaust, live_hit, load_out;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = paddr[lpmt_pkg::CFG_ADDR_W-1:2] == lpmt_pkg::REG_TABLE_SIZE;
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? lpmt_pkg::CFG_DATA_W'(table_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= lpmt_pkg::TSIZE_RESET;
    end else if (cfg_wr) begin
      table_size <= pwdata[lpmt_pkg::TSIZE_W-1:0];
    end
  end

  // size zero acts as one, sizes past the depth act as the depth
  always_comb begin
    if (table_size == '0) begin
      eff_n = lpmt_pkg::NUM_W'(1);
    end else if (32'(table_size) > lpmt_pkg::TABLE_DEPTH) begin
      eff_n = lpmt_pkg::NUM_W'(lpmt_pkg::TABLE_DEPTH);
    end else begin
      eff_n = lpmt_pkg::NUM_W'(table_size);
    end
  end

  assign in_stall  = state != lpmt_pkg::S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign rem_start = accept && (req_type inside {lpmt_pkg::REQ_LOOKUP,
                                                 lpmt_pkg::REQ_CREATE,
                                                 lpmt_pkg::REQ_REMOVE});

  lpmt_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (key),
    .divisor  (eff_n),
    .done     (rem_done),
    .rem      (rem)
  );

  lpmt_slot_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  // probe step
  assign at_inc    = {1'b0, at} + 1'b1;
  assign at_wrap   = (at_inc == n_q) ? '0 : at_inc[lpmt_pkg::SLOT_W-1:0];
  assign hit_never = !rd.ever_used;
  assign hit_key   = rd.key == key_q;
  assign hit_tomb  = (req_q == lpmt_pkg::REQ_CREATE) && !rd.live;
  assign stop      = hit_never || hit_key || hit_tomb;
  assign live_hit  = !hit_never && hit_key && rd.live;
  assign exhaust   = !stop && cnt == nm1;
  assign load_out  = !out_valid || !out_stall;

  always_comb begin
    state_next      = state;
    raddr           = at;
    we              = 1'b0;
    waddr           = at;
    wdata           = '0;
    res_status_next = lpmt_pkg::STAT_NOT_FOUND;
    res_value_next  = '0;
    case (state)
      lpmt_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == lpmt_pkg::SLOT_W'(lpmt_pkg::TABLE_DEPTH - 1)) begin
          state_next = lpmt_pkg::S_IDLE;
        end
      end
      lpmt_pkg::S_IDLE: begin
        if (rem_start) begin
          state_next = lpmt_pkg::S_DIV;
        end else if (accept) begin
          // unknown request type goes straight to its answer
          state_next = lpmt_pkg::S_DONE;
        end
      end
      lpmt_pkg::S_DIV: begin
        if (rem_done) begin
          state_next = lpmt_pkg::S_READ;
        end
      end
      lpmt_pkg::S_READ: begin
        state_next = lpmt_pkg::S_CHECK;
      end
      lpmt_pkg::S_CHECK: begin
        if (stop || exhaust) begin
          state_next = lpmt_pkg::S_DONE;
          case (req_q)
            lpmt_pkg::REQ_LOOKUP: begin
              if (live_hit) begin
                res_status_next = lpmt_pkg::STAT_OK;
                res_value_next  = rd.value;
              end
            end
            lpmt_pkg::REQ_CREATE: begin
              if (!stop) begin
                res_status_next = lpmt_pkg::STAT_FULL;
              end else if (live_hit) begin
                res_status_next = excl_q ? lpmt_pkg::STAT_EXISTS : lpmt_pkg::STAT_OK;
                res_value_next  = rd.value;
              end else begin
                res_status_next = lpmt_pkg::STAT_OK;
                res_value_next  = nval_q;
                we              = 1'b1;
                wdata           = '{ever_used: 1'b1, live: 1'b1, key: key_q, value: nval_q};
              end
            end
            lpmt_pkg::REQ_REMOVE: begin
              if (live_hit) begin
                res_status_next = lpmt_pkg::STAT_OK;
                res_value_next  = rd.value;
                we              = 1'b1;
                wdata           = '{ever_used: 1'b1, live: 1'b0, key: rd.key, value: rd.value};
              end
            end
            default: begin
              res_status_next = lpmt_pkg::STAT_NOT_FOUND;
            end
          endcase
        end else begin
          raddr = at_wrap;
        end
      end
      lpmt_pkg::S_DONE: begin
        if (load_out) begin
          state_next = lpmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lpmt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpmt_pkg::S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lpmt_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == lpmt_pkg::S_DONE && load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req_type;
      key_q      <= key;
      nval_q     <= new_value;
      excl_q     <= exclusive;
      n_q        <= eff_n;
      nm1        <= lpmt_pkg::SLOT_W'(eff_n - 1'b1);
      at         <= '0;
      res_status <= lpmt_pkg::STAT_NOT_FOUND;
      res_value  <= '0;
      res_live   <= 1'b0;
    end
    if (state == lpmt_pkg::S_DIV && rem_done) begin
      at  <= rem;
      cnt <= '0;
    end
    if (state == lpmt_pkg::S_CHECK) begin
      if (!stop) begin
        // exhausted probe ends back on the start slot
        at  <= at_wrap;
        cnt <= cnt + 1'b1;
      end
      res_status <= res_status_next;
      res_value  <= res_value_next;
      res_live   <= live_hit;
    end
    if (state == lpmt_pkg::S_DONE && load_out) begin
      status      <= res_status;
      found_value <= res_value;
      slot        <= at;
      was_present <= res_live;
    end
  end

endmodule

// ===== src/lpmt_rem.sv =====
// iterative remainder unit: one dividend bit per cycle
module lpmt_rem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lpmt_pkg::KEY_W-1:0]   dividend,
  input  logic [lpmt_pkg::NUM_W-1:0]   divisor,
  output logic                         done,
  output logic [lpmt_pkg::SLOT_W-1:0]  rem
);

  logic                        busy;
  logic [lpmt_pkg::CNT_W-1:0]  cnt;
  logic [lpmt_pkg::KEY_W-1:0]  quo;
  logic [lpmt_pkg::NUM_W-1:0]  div_q;
  logic [lpmt_pkg::NUM_W-1:0]  r_sh;
  logic [lpmt_pkg::NUM_W-1:0]  r_sub;
  logic [lpmt_pkg::SLOT_W-1:0] r_step;

  // restoring step: remainder stays below the divisor, so it fits the slot width
  always_comb begin
    r_sh  = {rem, quo[lpmt_pkg::KEY_W-1]};
    r_sub = r_sh - div_q;
    if (r_sh >= div_q) begin
      r_step = r_sub[lpmt_pkg::SLOT_W-1:0];
    end else begin
      r_step = r_sh[lpmt_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == lpmt_pkg::CNT_W'(lpmt_pkg::KEY_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      div_q <= divisor;
      rem   <= '0;
      cnt   <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      rem <= r_step;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== src/lpmt_slot_ram.sv =====
// slot memory: one write port, one read port with registered data
module lpmt_slot_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lpmt_pkg::SLOT_W-1:0] waddr,
  input  lpmt_pkg::slot_t             wdata,
  input  logic [lpmt_pkg::SLOT_W-1:0] raddr,
  output lpmt_pkg::slot_t             rdata
);

  lpmt_pkg::slot_t mem [lpmt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lpmt_checker.sv =====
// port-level checker for the map table, bound to the top level
`include "linear_probe_map_table_core_defines.svh"

module lpmt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  status,
  input logic [lpmt_pkg::VAL_W-1:0]  found_value,
  input logic                        was_present,
  input logic                        pready
);

  `LPMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(found_value), "result word changed while stalled")
  `LPMT_ASSERT(a_pready, pready, "pready dropped")
  `LPMT_ASSERT(a_full_empty,
               !(out_valid && status == lpmt_pkg::STAT_FULL) ||
               (found_value == '0 && !was_present), "full answer carries data")
  `LPMT_ASSERT(a_nf_empty,
               !(out_valid && status == lpmt_pkg::STAT_NOT_FOUND) ||
               (found_value == '0 && !was_present), "not_found answer carries data")
  `LPMT_ASSERT(a_exists_present,
               !(out_valid && status == lpmt_pkg::STAT_EXISTS) || was_present,
               "exists answer without a live entry")

endmodule

bind linear_probe_map_table_core lpmt_checker u_lpmt_checker (.*);

// ===== dv/tb_top.sv =====
// self-checking testbench for the linear probing map table core
module tb_top;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_WAIT     = 16;
  localparam int POOL_KEYS    = 10;
  localparam int PHASE_ITEMS  = 45;
  localparam int NUM_PHASES   = 14;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [lpmt_pkg::KEY_W-1:0] key;
    logic [lpmt_pkg::VAL_W-1:0] nval;
    logic                       excl;
  } request_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [lpmt_pkg::VAL_W-1:0]  value;
    logic [lpmt_pkg::SLOT_W-1:0] slot;
    logic                        present;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = lpmt_pkg::REQ_LOOKUP;
  logic [lpmt_pkg::KEY_W-1:0] key = '0;
  logic [lpmt_pkg::VAL_W-1:0] new_value = '0;
  logic exclusive = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [lpmt_pkg::VAL_W-1:0] found_value;
  logic [lpmt_pkg::SLOT_W-1:0] slot;
  logic was_present;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lpmt_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [lpmt_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [lpmt_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  linear_probe_map_table_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .key(key), .new_value(new_value), .exclusive(exclusive),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found_value(found_value), .slot(slot), .was_present(was_present),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // shadow copy of the slot table
  logic [lpmt_pkg::KEY_W-1:0] shadow_key [lpmt_pkg::TABLE_DEPTH];
  logic [lpmt_pkg::VAL_W-1:0] shadow_val [lpmt_pkg::TABLE_DEPTH];
  bit shadow_live [lpmt_pkg::TABLE_DEPTH];
  bit shadow_used [lpmt_pkg::TABLE_DEPTH];
  logic [lpmt_pkg::TSIZE_W-1:0] size_setting = lpmt_pkg::TSIZE_RESET;

  request_t queued_requests[$];
  reply_t predicted_replies[$];
  request_t on_port;
  int unanswered = 0;
  int send_gap = 0;
  bit send_burst = 1'b0;
  int hold_cycles = 0;
  bit recv_burst = 1'b0;
  int cycle_count = 0;
  bit failed = 1'b0;

  function automatic int span_of(logic [lpmt_pkg::TSIZE_W-1:0] sz);
    if (sz == 0) return 1;
    if (sz > lpmt_pkg::TABLE_DEPTH) return lpmt_pkg::TABLE_DEPTH;
    return int'(sz);
  endfunction

  // walk from key mod size; returns 0 when every slot in use was passed over
  function automatic bit probe_slot(logic [lpmt_pkg::KEY_W-1:0] k, bit for_create,
                                    output int pos, output bit hit);
    int n;
    int at;
    n = span_of(size_setting);
    at = int'(k % n);
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!shadow_used[at]) begin
        pos = at;
        return 1'b1;
      end
      if (shadow_key[at] == k) begin
        pos = at;
        hit = shadow_live[at];
        return 1'b1;
      end
      if (for_create && !shadow_live[at]) begin
        pos = at;
        return 1'b1;
      end
      at++;
      if (at >= n) at = 0;
    end
    pos = at;
    return 1'b0;
  endfunction

  function automatic reply_t map_request(request_t rq);
    reply_t r;
    int pos;
    bit hit;
    bit placed;
    r.status = lpmt_pkg::STAT_NOT_FOUND;
    r.value = '0;
    pos = 0;
    hit = 1'b0;
    case (rq.kind)
      lpmt_pkg::REQ_LOOKUP, lpmt_pkg::REQ_REMOVE: begin
        placed = probe_slot(rq.key, 1'b0, pos, hit);
        if (hit) begin
          r.status = lpmt_pkg::STAT_OK;
          r.value = shadow_val[pos];
          if (rq.kind == lpmt_pkg::REQ_REMOVE) shadow_live[pos] = 1'b0;
        end
      end
      lpmt_pkg::REQ_CREATE: begin
        placed = probe_slot(rq.key, 1'b1, pos, hit);
        if (!placed) begin
          r.status = lpmt_pkg::STAT_FULL;
        end else if (hit) begin
          r.status = rq.excl ? lpmt_pkg::STAT_EXISTS : lpmt_pkg::STAT_OK;
          r.value = shadow_val[pos];
        end else begin
          shadow_key[pos] = rq.key;
          shadow_val[pos] = rq.nval;
          shadow_live[pos] = 1'b1;
          shadow_used[pos] = 1'b1;
          r.status = lpmt_pkg::STAT_OK;
          r.value = rq.nval;
        end
      end
      default: ;
    endcase
    r.slot = lpmt_pkg::SLOT_W'(pos);
    r.present = hit;
    return r;
  endfunction

  function automatic void add_request(logic [1:0] kind, logic [lpmt_pkg::KEY_W-1:0] k,
                                      logic [lpmt_pkg::VAL_W-1:0] v, logic x);
    request_t rq;
    rq = '{kind: kind, key: k, nval: v, excl: x};
    queued_requests.push_back(rq);
    unanswered++;
  endfunction

  function automatic void note_mismatch(string field, logic [lpmt_pkg::VAL_W-1:0] want,
                                        logic [lpmt_pkg::VAL_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    failed = 1'b1;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(map_request(on_port));
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          on_port = queued_requests.pop_front();
          req_type <= on_port.kind;
          key <= on_port.key;
          new_value <= on_port.nval;
          exclusive <= on_port.excl;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: result word with none expected: status %0d value %h slot %0d",
                   $time, status, found_value, slot);
          failed = 1'b1;
        end else begin
          reply_t want;
          want = predicted_replies.pop_front();
          unanswered--;
          if (status !== want.status)
            note_mismatch("status", lpmt_pkg::VAL_W'(want.status), lpmt_pkg::VAL_W'(status));
          if (found_value !== want.value) note_mismatch("found_value", want.value, found_value);
          if (slot !== want.slot)
            note_mismatch("slot", lpmt_pkg::VAL_W'(want.slot), lpmt_pkg::VAL_W'(slot));
          if (was_present !== want.present)
            note_mismatch("was_present", lpmt_pkg::VAL_W'(want.present),
                          lpmt_pkg::VAL_W'(was_present));
        end
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        hold_cycles = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (out_valid && hold_cycles > 0) begin
        hold_cycles--;
      end
      out_stall <= (hold_cycles > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_table_size(logic [lpmt_pkg::TSIZE_W-1:0] sz, bit junk);
    logic [lpmt_pkg::CFG_DATA_W-1:0] word;
    word = junk ? lpmt_pkg::CFG_DATA_W'($urandom()) : '0;
    word[lpmt_pkg::TSIZE_W-1:0] = sz;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lpmt_pkg::CFG_ADDR_W'(lpmt_pkg::REG_TABLE_SIZE) << 2;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    size_setting = sz;
  endtask

  task automatic wait_all_answered();
    do @(posedge clk); while (unanswered != 0);
  endtask

  initial begin : stimulus
    logic [lpmt_pkg::TSIZE_W-1:0] phase_sizes [NUM_PHASES];
    logic [lpmt_pkg::KEY_W-1:0] pool [POOL_KEYS];
    logic [1:0] kind;
    logic [lpmt_pkg::KEY_W-1:0] k;
    int n;
    int pick;
    phase_sizes = '{11'd0, 11'd1, 11'd2047, 11'd3, 11'd16, 11'd5, 11'd1024,
                    11'd2, 11'd64, 11'd13, 11'd1, 11'd1024, 11'd7, 11'd0};
    phase_sizes[NUM_PHASES-1] = lpmt_pkg::TSIZE_W'($urandom_range(1, 40));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // table of four slots: collisions, wrap, tombstones and a full table
    write_table_size(11'd4, 1'b0);
    add_request(lpmt_pkg::REQ_LOOKUP, 31'd0, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_REMOVE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_request(lpmt_pkg::REQ_CREATE, 31'd0, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_CREATE, 31'd4, 32'hFFFF_FFFF, 1'b1);
    add_request(lpmt_pkg::REQ_CREATE, 31'd4, 32'h1234_5678, 1'b0);
    add_request(lpmt_pkg::REQ_CREATE, 31'd4, 32'h0BAD_F00D, 1'b1);
    add_request(lpmt_pkg::REQ_CREATE, 31'h7FFF_FFFF, 32'hA5A5_A5A5, 1'b0);
    add_request(lpmt_pkg::REQ_CREATE, 31'd7, 32'h5A5A_5A5A, 1'b0);
    add_request(lpmt_pkg::REQ_CREATE, 31'd11, 32'hDEAD_BEEF, 1'b0);
    add_request(lpmt_pkg::REQ_LOOKUP, 31'd11, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_REMOVE, 31'd11, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_REMOVE, 31'd4, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_LOOKUP, 31'd4, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_REMOVE, 31'd4, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_CREATE, 31'd8, 32'h0000_0001, 1'b1);
    add_request(lpmt_pkg::REQ_CREATE, 31'd4, 32'h8000_0000, 1'b0);
    add_request(REQ_SPARE, 31'd9, 32'h1111_1111, 1'b1);
    add_request(lpmt_pkg::REQ_REMOVE, 31'd0, 32'h0, 1'b0);
    add_request(lpmt_pkg::REQ_CREATE, 31'd4, 32'hCAFE_0004, 1'b1);
    add_request(lpmt_pkg::REQ_LOOKUP, 31'h7FFF_FFFF, 32'h0, 1'b0);
    add_request(REQ_SPARE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    wait_all_answered();

    foreach (phase_sizes[p]) begin
      write_table_size(phase_sizes[p], 1'($urandom_range(0, 1)));
      n = span_of(phase_sizes[p]);
      // small key set per phase so that creates, lookups and removes meet
      pool[0] = lpmt_pkg::KEY_W'($urandom());
      for (int j = 1; j < POOL_KEYS; j++) begin
        case ($urandom_range(0, 2))
          0: pool[j] = lpmt_pkg::KEY_W'($urandom());
          1: pool[j] = lpmt_pkg::KEY_W'($urandom_range(0, 4 * n));
          default: pool[j] = lpmt_pkg::KEY_W'(pool[0] + j * n);
        endcase
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) kind = lpmt_pkg::REQ_CREATE;
        else if (pick < 65) kind = lpmt_pkg::REQ_LOOKUP;
        else if (pick < 93) kind = lpmt_pkg::REQ_REMOVE;
        else kind = REQ_SPARE;
        if ($urandom_range(0, 9) == 0) k = lpmt_pkg::KEY_W'($urandom());
        else k = pool[$urandom_range(0, POOL_KEYS - 1)];
        add_request(kind, k, $urandom(), 1'($urandom_range(0, 1)));
      end
      wait_all_answered();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && predicted_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/lpmt_pkg.sv
src/lpmt_rem.sv
src/lpmt_slot_ram.sv
src/linear_probe_map_table_core.sv
src/lpmt_checker.sv
dv/tb_top.sv
